// File: src/bclt_pkg.sv
// ----------------------------------------------------------------------------
// bclt_pkg
// Shared types and constants for the binary cluster label table.
// ----------------------------------------------------------------------------
package bclt_pkg;

    // Field widths
    localparam int OPCODE_W = 2;
    localparam int VERTEX_W = 10;
    localparam int LABEL_W  = 2;
    localparam int NV_W     = 11;
    localparam int STATUS_W = 3;
    localparam int DIST_W   = 19;

    // Defaults
    localparam int MAX_VERTICES_DEF = 1024;
    localparam int NV_RESET         = 1024;

    typedef enum logic [OPCODE_W-1:0] {
        OP_SET_LABEL = 2'd0,
        OP_BEGIN     = 2'd1,
        OP_ADJ       = 2'd2,
        OP_CLEAR     = 2'd3
    } t_opcode;

    typedef enum logic [LABEL_W-1:0] {
        LBL_FIRST  = 2'd0,
        LBL_SECOND = 2'd1,
        LBL_NONE   = 2'd2,
        LBL_BAD    = 2'd3
    } t_label;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_BAD_LABEL  = 3'd1,
        ST_BAD_VERTEX = 3'd2,
        ST_SIZE_MISM  = 3'd3,
        ST_UNEXP_ADJ  = 3'd4
    } t_status;

endpackage

// File: src/bclt_if.sv
// ----------------------------------------------------------------------------
// bclt_in_if / bclt_out_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface bclt_in_if;
    import bclt_pkg::*;

    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [VERTEX_W-1:0] vertex;
    logic [LABEL_W-1:0]  label;
    logic [NV_W-1:0]     graph_size;
    logic                joined;

    modport source (output valid, opcode, vertex, label, graph_size, joined,
                    input ready);
    modport sink   (input valid, opcode, vertex, label, graph_size, joined,
                    output ready);
endinterface

interface bclt_out_if;
    import bclt_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [NV_W-1:0]     count_unclustered;
    logic [NV_W-1:0]     count_first;
    logic [NV_W-1:0]     count_second;
    logic [DIST_W-1:0]   distance;
    logic                distance_done;

    modport source (output valid, status, count_unclustered, count_first,
                    count_second, distance, distance_done,
                    input ready);
    modport sink   (input valid, status, count_unclustered, count_first,
                    count_second, distance, distance_done,
                    output ready);
endinterface

// File: src/binary_cluster_label_table_core.sv
// ----------------------------------------------------------------------------
// binary_cluster_label_table_core
// Per-vertex cluster label table with live class counts and a streaming
// correlation-clustering disagreement counter.
// ----------------------------------------------------------------------------
// Takes one input word per cycle while no sweep runs, no clear word waits in
// stage 1 and the output is not stalled, and returns one result word per input
// word: stage 1 holds the label memory read, the output register the update.
// The labels live in a memory with one write and two registered read ports; an
// adjacency word reads both vertices of its pair at once, and a write from the
// word ahead is forwarded to the reads. After reset, a configuration write and
// a clear word the memory is swept back to non-clustered, one entry a cycle
// over num_vertices entries (1024 after reset); no word is accepted during the
// sweep; a word after a clear word waits for it to leave stage 1.
module binary_cluster_label_table_core #(
    parameter int MAX_VERTICES = bclt_pkg::MAX_VERTICES_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [bclt_pkg::NV_W-1:0] i_cfg_data,
    bclt_in_if.sink                i_item,
    bclt_out_if.source             o_result
);
    import bclt_pkg::*;

    localparam int ADDR_W  = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NV_CAP  = (MAX_VERTICES < 2047) ? MAX_VERTICES : 2047;
    localparam int NV_RST  = (NV_RESET < NV_CAP) ? NV_RESET : NV_CAP;
    localparam logic [NV_W-1:0] NV_CAP_V = NV_W'(NV_CAP);
    localparam logic [NV_W-1:0] NV_RST_V = NV_W'(NV_RST);

    // Label memory
    logic [LABEL_W-1:0] r_mem [MAX_VERTICES];
    logic [LABEL_W-1:0] r_rd_a, r_rd_b;

    // Configuration and sweep
    logic [NV_W-1:0] r_nv;
    logic            r_sweep_act;
    logic [NV_W-1:0] r_sweep_cnt;

    // Pass control (advanced at acceptance)
    logic            r_pass_act;
    logic [NV_W-1:0] r_row, r_col;

    // Counts and distance (advanced at stage 1)
    logic [NV_W-1:0]   r_cnt_none, r_cnt_first, r_cnt_second;
    logic [DIST_W-1:0] r_dist;

    // Stage 1 word
    logic               r_s1_vld;
    t_opcode            r_s1_op;
    t_status            r_s1_status;
    logic               r_s1_done;
    logic [LABEL_W-1:0] r_s1_label;
    logic               r_s1_joined;
    logic [ADDR_W-1:0]  r_s1_addr;
    logic               r_s1_fa_hit, r_s1_fb_hit;
    logic [LABEL_W-1:0] r_s1_fa_data, r_s1_fb_data;

    // Output register
    logic                r_o_vld;
    logic [STATUS_W-1:0] r_o_status;
    logic [NV_W-1:0]     r_o_none, r_o_first, r_o_second;
    logic [DIST_W-1:0]   r_o_dist;
    logic                r_o_done;

    logic               adv, accept;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;
    logic [LABEL_W-1:0] wr_data;
    logic               s1_wr_en;
    logic [ADDR_W-1:0]  rd_addr_a, rd_addr_b;
    logic [NV_W-1:0]    cfg_nv;

    // Stage 0 decode
    t_status            s0_status;
    logic               s0_done;
    logic               n_pass_act;
    logic [NV_W-1:0]    n_row, n_col;
    logic [NV_W:0]      col_inc, col_wrap;

    // Stage 1 results
    logic [LABEL_W-1:0] lbl_a, lbl_b;
    logic [NV_W-1:0]    n_cnt_none, n_cnt_first, n_cnt_second;
    logic [DIST_W-1:0]  n_dist;
    logic               n_sweep_start;

    // Handshake
    assign adv    = r_s1_vld && (!r_o_vld || o_result.ready);
    assign i_item.ready = !r_sweep_act && !(r_s1_vld && (r_s1_op == OP_CLEAR))
                          && (!r_s1_vld || adv);
    assign accept = i_item.valid && i_item.ready;

    assign cfg_nv = (i_cfg_data > NV_CAP_V) ? NV_CAP_V : i_cfg_data;

    // Write port: sweep or the set_label of stage 1
    assign s1_wr_en = adv && (r_s1_op == OP_SET_LABEL) && (r_s1_status == ST_OK);
    always_comb begin
        if (r_sweep_act) begin
            wr_en   = 1'b1;
            wr_addr = ADDR_W'(r_sweep_cnt);
            wr_data = LBL_NONE;
        end else begin
            wr_en   = s1_wr_en;
            wr_addr = r_s1_addr;
            wr_data = r_s1_label;
        end
    end

    // Read addresses: vertex or row on port A, column on port B
    assign rd_addr_a = (t_opcode'(i_item.opcode) == OP_SET_LABEL) ?
                       ADDR_W'(i_item.vertex) : ADDR_W'(r_row);
    assign rd_addr_b = ADDR_W'(r_col);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (accept) begin
            r_rd_a <= r_mem[rd_addr_a];
            r_rd_b <= r_mem[rd_addr_b];
        end
    end

    // Stage 0: status and pair walk
    always_comb begin
        s0_status  = ST_OK;
        s0_done    = 1'b0;
        n_pass_act = r_pass_act;
        n_row      = r_row;
        n_col      = r_col;
        col_inc    = {1'b0, r_col} + 1'b1;
        col_wrap   = {1'b0, r_row} + 2'd2;
        case (t_opcode'(i_item.opcode))
            OP_SET_LABEL: begin
                if (i_item.label > LBL_SECOND) begin
                    s0_status = ST_BAD_LABEL;
                end else if ({1'b0, i_item.vertex} >= r_nv) begin
                    s0_status = ST_BAD_VERTEX;
                end
            end
            OP_BEGIN: begin
                if (i_item.graph_size != r_nv) begin
                    s0_status = ST_SIZE_MISM;
                end else begin
                    n_row = '0;
                    n_col = NV_W'(1);
                    if (r_nv < NV_W'(2)) begin
                        n_pass_act = 1'b0;
                        s0_done    = 1'b1;
                    end else begin
                        n_pass_act = 1'b1;
                    end
                end
            end
            OP_ADJ: begin
                if (!r_pass_act) begin
                    s0_status = ST_UNEXP_ADJ;
                end else if (col_inc >= {1'b0, r_nv}) begin
                    n_row = r_row + 1'b1;
                    n_col = NV_W'(col_wrap);
                    if (col_wrap >= {1'b0, r_nv}) begin
                        n_pass_act = 1'b0;
                        s0_done    = 1'b1;
                    end
                end else begin
                    n_col = NV_W'(col_inc);
                end
            end
            default: begin
            end
        endcase
    end

    // Stage 1: forwarded labels, counts and distance
    assign lbl_a = r_s1_fa_hit ? r_s1_fa_data : r_rd_a;
    assign lbl_b = r_s1_fb_hit ? r_s1_fb_data : r_rd_b;

    always_comb begin
        n_cnt_none    = r_cnt_none;
        n_cnt_first   = r_cnt_first;
        n_cnt_second  = r_cnt_second;
        n_dist        = r_dist;
        n_sweep_start = 1'b0;
        case (r_s1_op)
            OP_SET_LABEL: begin
                if (r_s1_status == ST_OK) begin
                    // one class gains, the old class loses
                    if (r_s1_label == LBL_FIRST) begin
                        n_cnt_first = n_cnt_first + 1'b1;
                    end else begin
                        n_cnt_second = n_cnt_second + 1'b1;
                    end
                    if (lbl_a == LBL_FIRST) begin
                        n_cnt_first = n_cnt_first - 1'b1;
                    end else if (lbl_a == LBL_SECOND) begin
                        n_cnt_second = n_cnt_second - 1'b1;
                    end else begin
                        n_cnt_none = n_cnt_none - 1'b1;
                    end
                end
            end
            OP_BEGIN: begin
                if (r_s1_status == ST_OK) begin
                    n_dist = '0;
                end
            end
            OP_ADJ: begin
                // disagreement: labels equal xor joined
                if ((r_s1_status == ST_OK) && ((lbl_a == lbl_b) != r_s1_joined)) begin
                    n_dist = r_dist + 1'b1;
                end
            end
            OP_CLEAR: begin
                n_cnt_none    = r_nv;
                n_cnt_first   = '0;
                n_cnt_second  = '0;
                n_sweep_start = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nv         <= NV_RST_V;
            r_sweep_act  <= (NV_RST_V != '0);
            r_sweep_cnt  <= '0;
            r_pass_act   <= 1'b0;
            r_row        <= '0;
            r_col        <= '0;
            r_cnt_none   <= NV_RST_V;
            r_cnt_first  <= '0;
            r_cnt_second <= '0;
            r_dist       <= '0;
            r_s1_vld     <= 1'b0;
            r_o_vld      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                // configuration write: new size, labels cleared, pass stopped
                r_nv         <= cfg_nv;
                r_cnt_none   <= cfg_nv;
                r_cnt_first  <= '0;
                r_cnt_second <= '0;
                r_pass_act   <= 1'b0;
                r_sweep_cnt  <= '0;
                r_sweep_act  <= (cfg_nv != '0);
            end else begin
                if (accept) begin
                    r_pass_act <= n_pass_act;
                    r_row      <= n_row;
                    r_col      <= n_col;
                end
                if (adv) begin
                    r_cnt_none   <= n_cnt_none;
                    r_cnt_first  <= n_cnt_first;
                    r_cnt_second <= n_cnt_second;
                    r_dist       <= n_dist;
                end
                // sweep start on a clear word, else the sweep walk
                if (adv && n_sweep_start) begin
                    r_sweep_cnt <= '0;
                    r_sweep_act <= (r_nv != '0);
                end else if (r_sweep_act) begin
                    r_sweep_cnt <= r_sweep_cnt + 1'b1;
                    if ({1'b0, r_sweep_cnt} + 1'b1 >= {1'b0, r_nv}) begin
                        r_sweep_act <= 1'b0;
                    end
                end
            end
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (adv) begin
                r_s1_vld <= 1'b0;
            end
            if (adv) begin
                r_o_vld <= 1'b1;
            end else if (o_result.ready) begin
                r_o_vld <= 1'b0;
            end
        end
    end

    // Stage 1 payload, with forwarding of the write in the accept cycle
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op      <= t_opcode'(i_item.opcode);
            r_s1_status  <= s0_status;
            r_s1_done    <= s0_done;
            r_s1_label   <= i_item.label;
            r_s1_joined  <= i_item.joined;
            r_s1_addr    <= ADDR_W'(i_item.vertex);
            r_s1_fa_hit  <= s1_wr_en && (r_s1_addr == rd_addr_a);
            r_s1_fb_hit  <= s1_wr_en && (r_s1_addr == rd_addr_b);
            r_s1_fa_data <= r_s1_label;
            r_s1_fb_data <= r_s1_label;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_o_status <= r_s1_status;
            r_o_none   <= n_cnt_none;
            r_o_first  <= n_cnt_first;
            r_o_second <= n_cnt_second;
            r_o_dist   <= n_dist;
            r_o_done   <= r_s1_done;
        end
    end

    assign o_result.valid             = r_o_vld;
    assign o_result.status            = r_o_status;
    assign o_result.count_unclustered = r_o_none;
    assign o_result.count_first       = r_o_first;
    assign o_result.count_second      = r_o_second;
    assign o_result.distance          = r_o_dist;
    assign o_result.distance_done     = r_o_done;

endmodule
